// File: src/bpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Shared sizes, codes, interface structs and helper functions.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Pool and tree sizes.
  localparam int MaxPages  = 1024;
  localparam int MaxOrder  = $clog2(MaxPages);
  localparam int TreeDepth = 2 * MaxPages - 1;
  localparam int AddrW     = $clog2(TreeDepth);
  localparam int NodeW     = MaxOrder + 1;
  localparam int OrderW    = 4;
  localparam int LogW      = 4;
  localparam int PagesW    = 11;
  localparam int OffsW     = 10;
  localparam int CountW    = 11;
  localparam int ArithW    = PagesW + 1;

  // Stream payload widths.
  localparam int InDataW   = 24;
  localparam int OutDataW  = 24;

  // Request kinds carried in the input tuser.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status carried in the output tuser.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_ROOT_CHK,
    ST_DSC_RDR,
    ST_DSC_PICK,
    ST_MARK,
    ST_UP_RDR,
    ST_UP_WR,
    ST_FREE_CHK,
    ST_COUNT,
    ST_DONE
  } bpa_state_e;

  // Operations of the shared node unit.
  typedef enum logic [2:0] {
    ALU_PICK,
    ALU_MAX,
    ALU_MERGE,
    ALU_SUB_FLOOR,
    ALU_ADD_SAT
  } alu_op_e;

  // Tree memory access for one cycle.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [NodeW-1:0] wdata;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

  // Node unit operands and result.
  typedef struct packed {
    alu_op_e           op;
    logic [ArithW-1:0] a;
    logic [ArithW-1:0] b;
    logic [ArithW-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [ArithW-1:0] y;
    logic              flag;
  } alu_rsp_t;

  // One result item.
  typedef struct packed {
    logic              status;
    logic [OffsW-1:0]  page_offset;
    logic [CountW-1:0] pages_left;
  } bpa_res_t;

  // Smallest k with 2^k >= n; a count of zero is taken as one page.
  function automatic logic [LogW-1:0] pages_log2_ceil(input logic [PagesW-1:0] n);
    logic [LogW-1:0] r;
    r = LogW'(PagesW);
    for (int k = PagesW; k >= 0; k--) begin
      if ((ArithW'(1) << k) >= ArithW'(n)) begin
        r = LogW'(k);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/bpa_tree_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tree node memory
// One write and one registered read per cycle, write-first on a collision.
// ----------------------------------------------------------------------------
module bpa_tree_ram (
  input  wire logic                   clk_i,
  input  bpa_pkg::ram_req_t           req_i,
  output logic [bpa_pkg::NodeW-1:0]   rdata_o
);
  import bpa_pkg::*;

  logic [NodeW-1:0] mem [TreeDepth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read port; a read of the node written in the same cycle sees the new value.
  always_ff @(posedge clk_i) begin
    if (req_i.we && (req_i.waddr == req_i.raddr)) begin
      rdata_o <= req_i.wdata;
    end else begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule
`default_nettype wire

// File: src/bpa_node_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared node unit
// Child selection, buddy merge and free-count arithmetic for the sequencer.
// ----------------------------------------------------------------------------
module bpa_node_alu (
  input  bpa_pkg::alu_req_t req_i,
  output bpa_pkg::alu_rsp_t rsp_o
);
  import bpa_pkg::*;

  logic [ArithW:0]   sum;
  logic [ArithW-1:0] big;
  logic [ArithW-1:0] room;
  logic              a_fits;
  logic              b_fits;

  // Common terms shared among the operations.
  assign sum    = {1'b0, req_i.a} + {1'b0, req_i.b};
  assign big    = (req_i.a > req_i.b) ? req_i.a : req_i.b;
  assign room   = req_i.c - req_i.a;
  assign a_fits = req_i.a >= req_i.c;
  assign b_fits = req_i.b >= req_i.c;

  // Operation select.
  always_comb begin
    rsp_o.y    = '0;
    rsp_o.flag = 1'b0;
    case (req_i.op)
      ALU_PICK: begin
        // Left wins when it fits and the right does not, or when both fit and it is not larger.
        rsp_o.flag = a_fits && (!b_fits || (req_i.a <= req_i.b));
      end
      ALU_MAX: begin
        rsp_o.y = big;
      end
      ALU_MERGE: begin
        // Two wholly free buddies make a wholly free parent.
        rsp_o.y = (sum == {1'b0, req_i.c}) ? req_i.c : big;
      end
      ALU_SUB_FLOOR: begin
        rsp_o.y = (req_i.a >= req_i.b) ? (req_i.a - req_i.b) : '0;
      end
      ALU_ADD_SAT: begin
        rsp_o.y = (req_i.b >= room) ? req_i.c : sum[ArithW-1:0];
      end
      default: begin
        rsp_o.y = big;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: src/bpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator sequencer
// Walks the tree one node access per cycle for rebuild, alloc and free.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_tvalid_i,
  output logic                           s_tready_o,
  input  wire logic [bpa_pkg::InDataW-1:0] s_tdata_i,
  input  wire logic                      s_tuser_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [bpa_pkg::OrderW-1:0] cfg_wdata_i,
  output bpa_pkg::ram_req_t              ram_req_o,
  input  wire logic [bpa_pkg::NodeW-1:0] ram_rdata_i,
  output bpa_pkg::alu_req_t              alu_req_o,
  input  bpa_pkg::alu_rsp_t              alu_rsp_i,
  output logic                           res_valid_o,
  input  wire logic                      res_ready_i,
  output bpa_pkg::bpa_res_t              res_o
);
  import bpa_pkg::*;

  bpa_state_e        state_q, state_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [LogW-1:0]   lvl_q, lvl_d;
  logic [AddrW-1:0]  lvl_end_q, lvl_end_d;
  logic [LogW-1:0]   req_log_q, req_log_d;
  logic [PagesW-1:0] n_q, n_d;
  logic              is_free_q, is_free_d;
  logic [NodeW-1:0]  l_q, l_d;
  logic              status_q, status_d;
  logic [OffsW-1:0]  offs_q, offs_d;
  logic [CountW-1:0] fc_q, fc_d;
  logic [OrderW-1:0] order_q, order_d;

  logic [PagesW-1:0] in_pages;
  logic [OffsW-1:0]  in_off;
  logic [PagesW-1:0] in_n;
  logic [AddrW-1:0]  leaf;
  logic              off_outside;
  logic              accept;
  logic [ArithW-1:0] pool_size;
  logic [ArithW-1:0] size;
  logic [ArithW-1:0] lvl_size;
  logic [AddrW-1:0]  parent;
  logic [AddrW-1:0]  lchild;
  logic [AddrW-1:0]  rchild;
  logic [AddrW-1:0]  nidx;
  logic [AddrW-1:0]  nlchild;
  logic [AddrW-1:0]  plchild;
  logic              idx_zero;
  logic              rd_zero;
  logic              root_fail;
  logic              dsc_stop;
  logic              pick_stop;
  logic              sweep_last;
  logic [OrderW-1:0] cfg_order;

  // Request fields and derived sizes.
  assign in_pages    = s_tdata_i[PagesW-1:0];
  assign in_off      = s_tdata_i[PagesW+OffsW-1:PagesW];
  assign in_n        = (in_pages == '0) ? PagesW'(1) : in_pages;
  assign pool_size   = ArithW'(1) << order_q;
  assign size        = ArithW'(1) << req_log_q;
  assign lvl_size    = ArithW'(1) << lvl_q;
  assign leaf        = AddrW'(in_off) + AddrW'(pool_size) - AddrW'(1);
  assign off_outside = ArithW'(in_off) >= pool_size;
  assign s_tready_o  = (state_q == ST_IDLE);
  assign accept      = s_tvalid_i && s_tready_o;

  // Tree index arithmetic.
  assign parent   = (idx_q - AddrW'(1)) >> 1;
  assign lchild   = {idx_q[AddrW-2:0], 1'b1};
  assign rchild   = lchild + AddrW'(1);
  assign nidx     = alu_rsp_i.flag ? lchild : rchild;
  assign nlchild  = {nidx[AddrW-2:0], 1'b1};
  assign plchild  = {parent[AddrW-2:0], 1'b1};

  // Loop conditions.
  assign idx_zero   = (idx_q == '0);
  assign rd_zero    = (ram_rdata_i == '0);
  assign root_fail  = (n_q > fc_q) || (size > ArithW'(ram_rdata_i));
  assign dsc_stop   = (lvl_q == req_log_q) || (lvl_q == '0);
  assign pick_stop  = ((lvl_q - LogW'(1)) == req_log_q) || (lvl_q == LogW'(1));
  assign sweep_last = (idx_q == lvl_end_q) && (lvl_q == '0);
  assign cfg_order  = (cfg_wdata_i > OrderW'(MaxOrder)) ? OrderW'(MaxOrder) : cfg_wdata_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SWEEP: begin
        if (sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser_i == REQ_FREE) begin
            state_d = off_outside ? ST_DONE : ST_FREE_CHK;
          end else begin
            state_d = ST_ROOT_CHK;
          end
        end
      end
      ST_ROOT_CHK: begin
        if (root_fail)     state_d = ST_DONE;
        else if (dsc_stop) state_d = ST_MARK;
        else               state_d = ST_DSC_RDR;
      end
      ST_DSC_RDR:  state_d = ST_DSC_PICK;
      ST_DSC_PICK: state_d = pick_stop ? ST_MARK : ST_DSC_RDR;
      ST_MARK:     state_d = idx_zero ? ST_COUNT : ST_UP_RDR;
      ST_UP_RDR:   state_d = ST_UP_WR;
      ST_UP_WR:    state_d = idx_zero ? ST_COUNT : ST_UP_RDR;
      ST_FREE_CHK: begin
        if (!rd_zero) state_d = idx_zero ? ST_DONE : ST_FREE_CHK;
        else          state_d = idx_zero ? ST_COUNT : ST_UP_RDR;
      end
      ST_COUNT:    state_d = ST_DONE;
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default:     state_d = ST_SWEEP;
    endcase
    // A pool order write restarts the rebuild from any state.
    if (cfg_we_i) state_d = ST_SWEEP;
  end

  // Memory and node unit control.
  always_comb begin
    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = idx_q;
    ram_req_o.wdata = '0;
    ram_req_o.raddr = '0;
    alu_req_o.op    = ALU_MAX;
    alu_req_o.a     = ArithW'(l_q);
    alu_req_o.b     = ArithW'(ram_rdata_i);
    alu_req_o.c     = lvl_size;
    case (state_q)
      ST_SWEEP: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.wdata = NodeW'(lvl_size);
      end
      ST_IDLE: begin
        ram_req_o.raddr = (s_tuser_i == REQ_FREE) ? leaf : '0;
      end
      ST_ROOT_CHK: begin
        ram_req_o.raddr = lchild;
      end
      ST_DSC_RDR: begin
        ram_req_o.raddr = rchild;
      end
      ST_DSC_PICK: begin
        alu_req_o.op    = ALU_PICK;
        alu_req_o.c     = size;
        ram_req_o.raddr = nlchild;
      end
      ST_MARK: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.raddr = plchild;
      end
      ST_UP_RDR: begin
        ram_req_o.raddr = rchild;
      end
      ST_UP_WR: begin
        alu_req_o.op    = is_free_q ? ALU_MERGE : ALU_MAX;
        ram_req_o.we    = 1'b1;
        ram_req_o.wdata = NodeW'(alu_rsp_i.y);
        ram_req_o.raddr = plchild;
      end
      ST_FREE_CHK: begin
        if (!rd_zero) begin
          ram_req_o.raddr = parent;
        end else begin
          // First used node on the path: restore it to its full size.
          ram_req_o.we    = 1'b1;
          ram_req_o.wdata = NodeW'(lvl_size);
          ram_req_o.raddr = plchild;
        end
      end
      ST_COUNT: begin
        alu_req_o.op = is_free_q ? ALU_ADD_SAT : ALU_SUB_FLOOR;
        alu_req_o.a  = ArithW'(fc_q);
        alu_req_o.b  = size;
        alu_req_o.c  = pool_size;
      end
      default: begin
        ram_req_o.we = 1'b0;
      end
    endcase
  end

  // Datapath register updates.
  always_comb begin
    idx_d     = idx_q;
    lvl_d     = lvl_q;
    lvl_end_d = lvl_end_q;
    req_log_d = req_log_q;
    n_d       = n_q;
    is_free_d = is_free_q;
    l_d       = l_q;
    status_d  = status_q;
    offs_d    = offs_q;
    fc_d      = fc_q;
    order_d   = order_q;
    case (state_q)
      ST_SWEEP: begin
        idx_d = idx_q + AddrW'(1);
        if ((idx_q == lvl_end_q) && (lvl_q != '0)) begin
          lvl_d     = lvl_q - LogW'(1);
          lvl_end_d = AddrW'((ArithW'(lvl_end_q) << 1) + ArithW'(2));
        end
      end
      ST_IDLE: begin
        if (accept) begin
          is_free_d = (s_tuser_i == REQ_FREE);
          n_d       = in_n;
          req_log_d = pages_log2_ceil(in_pages);
          status_d  = STATUS_OK;
          offs_d    = '0;
          if (s_tuser_i == REQ_FREE) begin
            idx_d = leaf;
            lvl_d = '0;
          end else begin
            idx_d = '0;
            lvl_d = LogW'(order_q);
          end
        end
      end
      ST_ROOT_CHK: begin
        if (root_fail) status_d = STATUS_FAIL;
      end
      ST_DSC_RDR: begin
        l_d = ram_rdata_i;
      end
      ST_DSC_PICK: begin
        idx_d = nidx;
        lvl_d = lvl_q - LogW'(1);
      end
      ST_MARK: begin
        // First page of the block is its rank within its level times its size.
        offs_d = OffsW'(((ArithW'(idx_q) + ArithW'(1)) << lvl_q) - pool_size);
        if (!idx_zero) begin
          idx_d = parent;
          lvl_d = lvl_q + LogW'(1);
        end
      end
      ST_UP_RDR: begin
        l_d = ram_rdata_i;
      end
      ST_UP_WR, ST_FREE_CHK: begin
        if (!idx_zero) begin
          idx_d = parent;
          lvl_d = lvl_q + LogW'(1);
        end
      end
      ST_COUNT: begin
        fc_d = CountW'(alu_rsp_i.y);
      end
      default: begin
        idx_d = idx_q;
      end
    endcase
    // Rebuild setup on a pool order write.
    if (cfg_we_i) begin
      order_d   = cfg_order;
      fc_d      = CountW'(ArithW'(1) << cfg_order);
      idx_d     = '0;
      lvl_d     = LogW'(cfg_order);
      lvl_end_d = '0;
    end
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_SWEEP;
      idx_q     <= '0;
      lvl_q     <= LogW'(MaxOrder);
      lvl_end_q <= '0;
      is_free_q <= 1'b0;
      fc_q      <= CountW'(MaxPages);
      order_q   <= OrderW'(MaxOrder);
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      lvl_q     <= lvl_d;
      lvl_end_q <= lvl_end_d;
      is_free_q <= is_free_d;
      fc_q      <= fc_d;
      order_q   <= order_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_log_q <= req_log_d;
    n_q       <= n_d;
    l_q       <= l_d;
    status_q  <= status_d;
    offs_q    <= offs_d;
  end

  // Result handed to the output stage.
  assign res_valid_o       = (state_q == ST_DONE);
  assign res_o.status      = status_q;
  assign res_o.page_offset = offs_q;
  assign res_o.pages_left  = fc_q;

endmodule
`default_nettype wire

// File: src/buddy_page_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy page allocator
// Power-of-two page blocks over a tree of largest free block sizes.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_axis channel: tuser selects allocate (0) or free (1),
// tdata carries the page count and, for a free, the block offset. Each request
// yields exactly one result on m_axis: tuser is the status, tdata holds the
// allocated page offset and the free page count after the request.
// The pool order is written through cfg_we_i / cfg_wdata_i while idle; the
// user is bound to that, as the block does not enforce it. Each write
// rebuilds the tree as wholly free.
// An allocate that cannot be met fails at the root check; a successful one
// descends to the block, marks it used and rewrites its ancestors. A free
// climbs from the leaf to the first used node, restores it and rewrites its
// ancestors; one with no used node on its path, or with an offset outside
// the pool, is ignored. One request is in flight at a time, and the single
// tree memory serves one node read per cycle.
// After reset and after each pool order write the tree is swept, one node per
// cycle, 2^(pool_order+1)-1 nodes (2047 after reset), with s_axis_tready_o low.
// A result waits in an output register while m_axis_tready_i is low; the next
// request is accepted meanwhile and its result holds until that slot empties.
// ----------------------------------------------------------------------------
module buddy_page_allocator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: req_pages [10:0], block_offset [20:11], zero fill [23:21]
  input  wire logic [bpa_pkg::InDataW-1:0]   s_axis_tdata_i,
  // tuser: req_type [0]
  input  wire logic [0:0]                    s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // tdata: page_offset [9:0], pages_left [20:10], zero fill [23:21]
  output logic [bpa_pkg::OutDataW-1:0]       m_axis_tdata_o,
  // tuser: status [0]
  output logic [0:0]                         m_axis_tuser_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [bpa_pkg::OrderW-1:0]    cfg_wdata_i
);
  import bpa_pkg::*;

  ram_req_t         ram_req;
  logic [NodeW-1:0] ram_rdata;
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  logic             res_valid;
  logic             res_ready;
  bpa_res_t         res;
  logic             out_valid_q, out_valid_d;
  bpa_res_t         out_res_q;

  bpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i[0]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  bpa_tree_ram u_tree_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  bpa_node_alu u_node_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Output slot: free when empty or being taken this cycle.
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  // Output packing.
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_res_q.status;
  assign m_axis_tdata_o  = OutDataW'({out_res_q.pages_left, out_res_q.page_offset});

endmodule
`default_nettype wire

// File: src/bpa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy page allocator port checker
// Checks result and handshake behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module bpa_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        s_axis_tvalid_i,
  input wire logic                        s_axis_tready_o,
  input wire logic                        m_axis_tvalid_o,
  input wire logic                        m_axis_tready_i,
  input wire logic [bpa_pkg::OutDataW-1:0] m_axis_tdata_o,
  input wire logic [0:0]                  m_axis_tuser_o
);
  import bpa_pkg::*;

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // Only one request is in flight: ready drops right after an accept.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted while another was in flight");

  // A failed allocation reports page offset zero.
  a_fail_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[0] == STATUS_FAIL) |->
      m_axis_tdata_o[OffsW-1:0] == '0)
    else $error("failed allocation with nonzero offset");

  // The free page count never exceeds the largest pool.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OffsW+CountW-1:OffsW] <= CountW'(MaxPages))
    else $error("free page count above pool size");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);
`default_nettype wire
